// ===== sv/swm_pkg.sv =====
// Package for the sliding-window min/max/mean block.
// Holds sizes, derived widths and the control struct shared by the cell row.
// No dependencies.
package swm_pkg;

  // Window depth and sample width
  localparam int unsigned WINDOW_MAX  = 64;
  localparam int unsigned SAMPLE_BITS = 32;

  // Derived widths
  localparam int unsigned SLOT_BITS  = $clog2(WINDOW_MAX);
  localparam int unsigned COUNT_BITS = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUM_BITS   = SAMPLE_BITS + SLOT_BITS;
  localparam int unsigned STEP_BITS  = $clog2(SUM_BITS);
  localparam int unsigned LEN_BITS   = 7;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_BITS  = 2 * SAMPLE_BITS;
  localparam int unsigned IN_BYTES = (IN_BITS + 7) / 8;
  localparam int unsigned RES_BITS = 6 * SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned OUT_BYTES = (RES_BITS + 7) / 8;
  localparam int unsigned OUT_PAD  = 8 * OUT_BYTES - RES_BITS;

  // Per-cycle command to every cell of the row
  typedef struct packed {
    logic shift_in;  // take the neighbour on the newer side
    logic rotate;    // take the neighbour on the older side
  } cell_ctl_t;

endpackage

// ===== sv/swm_cell.sv =====
// One window cell: holds a duration and an interval sample.
// Shifts in a newer sample or rotates an older one in; uses swm_pkg.
module swm_cell (
  input  logic                               clk_i,
  input  swm_pkg::cell_ctl_t                 ctl_i,
  input  logic [swm_pkg::SAMPLE_BITS-1:0]    prev_dur_i,
  input  logic [swm_pkg::SAMPLE_BITS-1:0]    prev_int_i,
  input  logic [swm_pkg::SAMPLE_BITS-1:0]    next_dur_i,
  input  logic [swm_pkg::SAMPLE_BITS-1:0]    next_int_i,
  output logic [swm_pkg::SAMPLE_BITS-1:0]    dur_o,
  output logic [swm_pkg::SAMPLE_BITS-1:0]    int_o
);

  logic [swm_pkg::SAMPLE_BITS-1:0] dur_q, dur_d;
  logic [swm_pkg::SAMPLE_BITS-1:0] int_q, int_d;

  // Select source for this cycle
  always_comb begin
    dur_d = dur_q;
    int_d = int_q;
    if (ctl_i.shift_in) begin
      dur_d = prev_dur_i;
      int_d = prev_int_i;
    end else if (ctl_i.rotate) begin
      dur_d = next_dur_i;
      int_d = next_int_i;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    dur_q <= dur_d;
    int_q <= int_d;
  end

  assign dur_o = dur_q;
  assign int_o = int_q;

endmodule

// ===== sv/swm_div.sv =====
// Bit-serial restoring divider: window sum by sample count, one bit a cycle.
// Raises done_o after the last quotient bit; uses swm_pkg.
module swm_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [swm_pkg::SUM_BITS-1:0]       dividend_i,
  input  logic [swm_pkg::COUNT_BITS-1:0]     divisor_i,
  output logic                               done_o,
  output logic [swm_pkg::SAMPLE_BITS-1:0]    quotient_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [swm_pkg::STEP_BITS-1:0]     cnt_q, cnt_d;
  logic [swm_pkg::COUNT_BITS-1:0]    rem_q, rem_d;
  logic [swm_pkg::SUM_BITS-1:0]      quo_q, quo_d;
  logic [swm_pkg::COUNT_BITS-1:0]    dsr_q, dsr_d;
  logic [swm_pkg::COUNT_BITS:0]      rem_sh;
  logic [swm_pkg::COUNT_BITS:0]      rem_sub;

  // One restoring step: remainder stays below the divisor
  always_comb begin
    rem_sh  = {rem_q, quo_q[swm_pkg::SUM_BITS-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = swm_pkg::STEP_BITS'(swm_pkg::SUM_BITS - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d = rem_sub[swm_pkg::COUNT_BITS-1:0];
        quo_d = {quo_q[swm_pkg::SUM_BITS-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[swm_pkg::COUNT_BITS-1:0];
        quo_d = {quo_q[swm_pkg::SUM_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[swm_pkg::SAMPLE_BITS-1:0];

endmodule

// ===== sv/sliding_window_min_max_mean.sv =====
// Sliding-window min/max/mean over the last window_length samples.
// A transfer starts a 64-step rotation of the cell row past the folding unit, then a
// 38-step serial divide; the next sample is taken only back in idle, after the result
// register is loaded, which waits while the previous result is still held.
// Reset: window_length 10, window empty; cell contents undefined until written.
module sliding_window_min_max_mean (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Configuration write: window_length
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [6:0]    cfg_data_i,
  // Sample input
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [63:0]   s_axis_tdata_i,   // [31:0] duration, [63:32] interval
  // Result output
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [31:0] min_duration, [63:32] max_duration, [95:64] mean_duration,
  // [127:96] min_interval, [159:128] max_interval, [191:160] mean_interval,
  // [198:192] sample_count, [199] zero
  output logic [199:0]  m_axis_tdata_o
);

  localparam int unsigned W  = swm_pkg::SAMPLE_BITS;
  localparam int unsigned N  = swm_pkg::WINDOW_MAX;
  localparam int unsigned CB = swm_pkg::COUNT_BITS;
  localparam int unsigned SB = swm_pkg::SUM_BITS;

  // Sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                      state_q, state_d;
  logic [swm_pkg::LEN_BITS-1:0]    wlen_q;
  logic [CB-1:0]                   fill_q, fill_d;
  logic [CB-1:0]                   eff_len;
  logic [swm_pkg::SLOT_BITS-1:0]   scan_q, scan_d;
  logic                            in_xfer;
  logic                            fold;

  logic [W-1:0]  dmin_q, dmin_d, dmax_q, dmax_d;
  logic [W-1:0]  imin_q, imin_d, imax_q, imax_d;
  logic [SB-1:0] dsum_q, dsum_d, isum_q, isum_d;

  logic          div_start;
  logic          ddiv_done, idiv_done;
  logic [W-1:0]  dmean, imean;

  logic          out_valid_q;
  logic [W-1:0]  o_dmin_q, o_dmax_q, o_dmean_q, o_imin_q, o_imax_q, o_imean_q;
  logic [CB-1:0] o_cnt_q;
  logic          out_load;

  swm_pkg::cell_ctl_t ctl;
  logic [W-1:0] cell_dur [N];
  logic [W-1:0] cell_int [N];

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // Effective window length: zero counts as one, saturate at the depth
  always_comb begin
    if (wlen_q == '0) begin
      eff_len = CB'(1);
    end else if (32'(wlen_q) > N) begin
      eff_len = CB'(N);
    end else begin
      eff_len = CB'(wlen_q);
    end
  end

  // Cell row: newest sample at cell 0; rotation brings cell k to cell 0 at step k
  assign ctl.shift_in = in_xfer;
  assign ctl.rotate   = (state_q == ST_SCAN);

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [W-1:0] prev_dur, prev_int;
    if (k == 0) begin : g_head
      assign prev_dur = s_axis_tdata_i[W-1:0];
      assign prev_int = s_axis_tdata_i[2*W-1:W];
    end else begin : g_body
      assign prev_dur = cell_dur[k-1];
      assign prev_int = cell_int[k-1];
    end
    swm_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .prev_dur_i (prev_dur),
      .prev_int_i (prev_int),
      .next_dur_i (cell_dur[(k + 1) % N]),
      .next_int_i (cell_int[(k + 1) % N]),
      .dur_o      (cell_dur[k]),
      .int_o      (cell_int[k])
    );
  end

  // Sequencer and folding of cell 0 into the running min/max/sum
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    scan_d    = scan_q;
    dmin_d    = dmin_q;
    dmax_d    = dmax_q;
    imin_d    = imin_q;
    imax_d    = imax_q;
    dsum_d    = dsum_q;
    isum_d    = isum_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    fold      = ({1'b0, scan_q} < fill_q);
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          fill_d  = (fill_q + 1'b1 > eff_len) ? eff_len : fill_q + 1'b1;
          scan_d  = '0;
          dmin_d  = '1;
          dmax_d  = '0;
          imin_d  = '1;
          imax_d  = '0;
          dsum_d  = '0;
          isum_d  = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (fold) begin
          if (cell_dur[0] < dmin_q) dmin_d = cell_dur[0];
          if (cell_dur[0] > dmax_q) dmax_d = cell_dur[0];
          if (cell_int[0] < imin_q) imin_d = cell_int[0];
          if (cell_int[0] > imax_q) imax_d = cell_int[0];
          dsum_d = dsum_q + SB'(cell_dur[0]);
          isum_d = isum_q + SB'(cell_int[0]);
        end
        scan_d = scan_q + 1'b1;
        if (scan_q == swm_pkg::SLOT_BITS'(N - 1)) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // dividers are started on entry, finish together
        if (ddiv_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (state_q == ST_SCAN && scan_q == swm_pkg::SLOT_BITS'(N - 1)) begin
      div_start = 1'b1;
    end
  end

  // Dividers start in the cycle after the last scan step, when the sums are final
  logic div_go_q;

  swm_div u_ddiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (dsum_q),
    .divisor_i  (fill_q),
    .done_o     (ddiv_done),
    .quotient_o (dmean)
  );

  swm_div u_idiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (isum_q),
    .divisor_i  (fill_q),
    .done_o     (idiv_done),
    .quotient_o (imean)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wlen_q      <= swm_pkg::LEN_BITS'(10);
      fill_q      <= '0;
      scan_q      <= '0;
      div_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      scan_q   <= scan_d;
      div_go_q <= div_start;
      if (cfg_valid_i && cfg_ready_o) begin
        wlen_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Accumulators and result register
  always_ff @(posedge clk_i) begin
    dmin_q <= dmin_d;
    dmax_q <= dmax_d;
    imin_q <= imin_d;
    imax_q <= imax_d;
    dsum_q <= dsum_d;
    isum_q <= isum_d;
    if (out_load) begin
      o_dmin_q  <= dmin_q;
      o_dmax_q  <= dmax_q;
      o_dmean_q <= dmean;
      o_imin_q  <= imin_q;
      o_imax_q  <= imax_q;
      o_imean_q <= imean;
      o_cnt_q   <= fill_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{swm_pkg::OUT_PAD{1'b0}}, o_cnt_q, o_imean_q, o_imax_q,
                            o_imin_q, o_dmean_q, o_dmax_q, o_dmin_q};

  // Checks
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ddiv_done == idiv_done)
    else $error("dividers out of step");

  a_xfer_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_SCAN) && (scan_q == '0))
    else $error("transfer did not start the scan");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (fill_q != '0) && (fill_q <= eff_len))
    else $error("fill count out of range");

  a_result_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (o_dmin_q <= o_dmean_q) && (o_dmean_q <= o_dmax_q)
                         && (o_imin_q <= o_imean_q) && (o_imean_q <= o_imax_q))
    else $error("mean outside min/max");

endmodule

// ===== verif/sliding_window_min_max_mean_test.sv =====
// Testbench for sliding_window_min_max_mean: directed table, then random phases
// over several window lengths, each result checked against the table or a local window model.
// Depends on swm_pkg and the sliding_window_min_max_mean RTL.
module sliding_window_min_max_mean_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW_MAX   = swm_pkg::WINDOW_MAX;
  localparam int unsigned SAMPLE_BITS  = swm_pkg::SAMPLE_BITS;
  localparam int unsigned SLOT_BITS    = swm_pkg::SLOT_BITS;
  localparam int unsigned COUNT_BITS   = swm_pkg::COUNT_BITS;
  localparam int unsigned LEN_BITS     = swm_pkg::LEN_BITS;
  localparam int unsigned OUT_PAD      = swm_pkg::OUT_PAD;

  localparam int unsigned RANDOM_ITEMS = 1930;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned IDLE_PCT     = 29;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic [OUT_PAD-1:0]    pad;
    logic [COUNT_BITS-1:0] count;
    sample_t               mean_i;
    sample_t               max_i;
    sample_t               min_i;
    sample_t               mean_d;
    sample_t               max_d;
    sample_t               min_d;
  } stats_t;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [LEN_BITS-1:0] len;
    sample_t           dur;
    sample_t           ivl;
    bit                typed;
    stats_t            want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [6:0]          cfg_data_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [63:0]         s_axis_tdata_i;   // [31:0] duration, [63:32] interval
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  // [31:0] min_duration, [63:32] max_duration, [95:64] mean_duration,
  // [127:96] min_interval, [159:128] max_interval, [191:160] mean_interval,
  // [198:192] sample_count, [199] zero
  logic [199:0]        m_axis_tdata_o;

  // Window model state
  sample_t               dur_hist [WINDOW_MAX];
  sample_t               ivl_hist [WINDOW_MAX];
  logic [SLOT_BITS-1:0]  head_slot;
  logic [COUNT_BITS-1:0] held_count;
  logic [LEN_BITS-1:0]   len_reg;

  stats_t      pending_stats [$];
  stim_row_t   directed [$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct    = IDLE_PCT;
  bit          hold_req    = 1'b0;

  sliding_window_min_max_mean uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Append one sample, trim to the effective length, fold the window
  function automatic stats_t fold_window(sample_t dur, sample_t ivl);
    stats_t               r;
    int unsigned          span;
    logic [63:0]          dsum;
    logic [63:0]          isum;
    logic [SLOT_BITS-1:0] slot;
    span = (len_reg == 0) ? 1 : ((len_reg > WINDOW_MAX) ? WINDOW_MAX : len_reg);
    dur_hist[head_slot] = dur;
    ivl_hist[head_slot] = ivl;
    head_slot = head_slot + 1'b1;
    if (held_count < span) begin
      held_count = held_count + 1'b1;
    end else begin
      held_count = COUNT_BITS'(span);
    end
    r = '0;
    r.min_d = '1;
    r.min_i = '1;
    dsum = '0;
    isum = '0;
    for (int k = 0; k < held_count; k++) begin
      slot = head_slot - SLOT_BITS'(k + 1);
      dsum = dsum + dur_hist[slot];
      isum = isum + ivl_hist[slot];
      if (dur_hist[slot] < r.min_d) r.min_d = dur_hist[slot];
      if (dur_hist[slot] > r.max_d) r.max_d = dur_hist[slot];
      if (ivl_hist[slot] < r.min_i) r.min_i = ivl_hist[slot];
      if (ivl_hist[slot] > r.max_i) r.max_i = ivl_hist[slot];
    end
    r.mean_d = sample_t'(dsum / 64'(held_count));
    r.mean_i = sample_t'(isum / 64'(held_count));
    r.count  = held_count;
    return r;
  endfunction

  // Mostly full-range values, with extremes, small values and repeats mixed in
  function automatic sample_t pick_sample(sample_t prev);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return sample_t'($urandom_range(15));
      3:       return prev;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic stim_row_t cfg_row(logic [LEN_BITS-1:0] len);
    stim_row_t r;
    r = '{kind: ROW_CFG, len: len, dur: '0, ivl: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t sample_row(sample_t dur, sample_t ivl,
                                           bit typed = 1'b0, stats_t want = '0);
    stim_row_t r;
    r = '{kind: ROW_SAMPLE, len: '0, dur: dur, ivl: ivl, typed: typed, want: want};
    return r;
  endfunction

  // Table and scoreboard appends
  function automatic void add_row(stim_row_t r);
    directed.insert(directed.size(), r);
  endfunction

  function automatic void note_result(stats_t s);
    pending_stats.insert(pending_stats.size(), s);
  endfunction

  function automatic void check_field(string name, sample_t want, sample_t got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  // Offer one sample; on transfer, queue what it should produce
  task automatic send_sample(sample_t dur, sample_t ivl, bit typed, stats_t want);
    stats_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {ivl, dur};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = fold_window(dur, ivl);
    note_result(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Drop the sample stream and let every pending result drain
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [LEN_BITS-1:0] len);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    len_reg = len;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result receiver: random back-pressure, plus one long hold-off on request
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    stats_t got;
    stats_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (pending_stats.size() == 0) begin
        $error("result transfer with nothing pending: %h", got);
        fail_count++;
      end else begin
        want = pending_stats.pop_front();
        check_field("min_duration", want.min_d, got.min_d);
        check_field("max_duration", want.max_d, got.max_d);
        check_field("mean_duration", want.mean_d, got.mean_d);
        check_field("min_interval", want.min_i, got.min_i);
        check_field("max_interval", want.max_i, got.max_i);
        check_field("mean_interval", want.mean_i, got.mean_i);
        check_field("sample_count", sample_t'(want.count), sample_t'(got.count));
      end
    end
  end

  // Stimulus
  initial begin
    sample_t             dur;
    sample_t             ivl;
    logic [LEN_BITS-1:0] len;
    logic [LEN_BITS-1:0] len_plan [7];
    int unsigned         sent;
    int unsigned         phase;
    int unsigned         span;
    int unsigned         burst;

    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    head_slot       = '0;
    held_count      = '0;
    len_reg         = LEN_BITS'(10);
    len_plan        = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd65, 7'd33, 7'd2};

    // Directed table: extremes first, then window trimming and length limits
    add_row(sample_row(32'hFFFF_FFFF, 32'h0, 1'b1,
      stats_t'{pad: '0, count: 7'd1,
               mean_i: 32'h0, max_i: 32'h0, min_i: 32'h0,
               mean_d: 32'hFFFF_FFFF, max_d: 32'hFFFF_FFFF, min_d: 32'hFFFF_FFFF}));
    add_row(sample_row(32'h0, 32'hFFFF_FFFF, 1'b1,
      stats_t'{pad: '0, count: 7'd2,
               mean_i: 32'h7FFF_FFFF, max_i: 32'hFFFF_FFFF, min_i: 32'h0,
               mean_d: 32'h7FFF_FFFF, max_d: 32'hFFFF_FFFF, min_d: 32'h0}));
    // Past the reset length of ten, so the oldest drop out
    for (int k = 1; k <= 10; k++) begin
      add_row(sample_row(sample_t'(k * 1000), 32'h8000_0000 + k));
    end
    // Lowered length trims at the next sample
    add_row(cfg_row(7'd3));
    add_row(sample_row(32'h0000_0007, 32'hFFFF_FFFE));
    add_row(sample_row(32'hFFFF_FFFF, 32'h0000_0001));
    // Zero length behaves as one
    add_row(cfg_row(7'd0));
    add_row(sample_row(32'h1234_5678, 32'h9ABC_DEF0, 1'b1,
      stats_t'{pad: '0, count: 7'd1,
               mean_i: 32'h9ABC_DEF0, max_i: 32'h9ABC_DEF0, min_i: 32'h9ABC_DEF0,
               mean_d: 32'h1234_5678, max_d: 32'h1234_5678, min_d: 32'h1234_5678}));
    // Oversized length saturates; trimmed samples stay gone
    add_row(cfg_row(7'd127));
    add_row(sample_row(32'hA5A5_A5A5, 32'h5A5A_5A5A));
    add_row(sample_row(32'h5A5A_5A5A, 32'hA5A5_A5A5));
    add_row(cfg_row(7'd1));
    add_row(sample_row(32'hDEAD_BEEF, 32'h0000_0001, 1'b1,
      stats_t'{pad: '0, count: 7'd1,
               mean_i: 32'h1, max_i: 32'h1, min_i: 32'h1,
               mean_d: 32'hDEAD_BEEF, max_d: 32'hDEAD_BEEF, min_d: 32'hDEAD_BEEF}));
    add_row(cfg_row(7'd64));
    add_row(sample_row(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_row(sample_row(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_row(sample_row(32'h0000_0003, 32'h0000_0003));
    add_row(sample_row(32'h8000_0000, 32'h7FFF_FFFF));

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[n]) begin
      if (directed[n].kind == ROW_CFG) begin
        wait_idle();
        write_cfg(directed[n].len);
      end else begin
        send_sample(directed[n].dur, directed[n].ivl, directed[n].typed,
                    directed[n].want);
      end
    end

    // Random phases, each under its own window length
    sent  = 0;
    phase = 0;
    dur   = '0;
    ivl   = '0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      len = (phase < 7) ? len_plan[phase] : LEN_BITS'($urandom_range(0, 127));
      write_cfg(len);
      idle_pct = (phase == 2) ? 0 : IDLE_PCT;
      if (phase == 3) hold_req = 1'b1;
      span  = (len > WINDOW_MAX) ? WINDOW_MAX : len;
      burst = (span >= 48) ? $urandom_range(80, 160) : $urandom_range(20, 120);
      for (int j = 0; j < burst; j++) begin
        dur = pick_sample(dur);
        ivl = pick_sample(ivl);
        send_sample(dur, ivl, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_stats.size() != 0) begin
      $error("%0d results never arrived", pending_stats.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
